@@ design/amgs_pkg.sv @@
// amgs_pkg: shared types and constants for the adjacency matrix graph store
// used by amgs_matrix and adjacency_matrix_graph_store; no dependencies
`default_nettype none

package amgs_pkg;

    // number of vertices in the matrix (2 to 64)
    localparam int VERTICES = 64;

    // fixed field widths of the item ports
    localparam int OP_W     = 3;
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 13;

    // derived widths: row address and walk position (must hold VERTICES)
    localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int VCW = VW + 1;

    typedef logic [VERTEX_W-1:0] t_vtx;
    typedef logic [VW-1:0]       t_addr;
    typedef logic [VCW-1:0]      t_next;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [VERTICES-1:0] t_row;

    // limits used by range checks
    localparam logic [VERTEX_W:0] VLIMIT    = (VERTEX_W + 1)'(VERTICES);
    localparam t_next             NEXT_END  = t_next'(VERTICES);
    localparam t_count            COUNT_MAX = '1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_QUERY  = 3'd2,
        OP_BEGIN  = 3'd3,
        OP_NEXT   = 3'd4
    } t_op;

    // one bit write into the matrix, plus its mirrored copy when mirror is set
    typedef struct packed {
        logic  en;
        logic  mirror;
        logic  val;
        t_addr u;
        t_addr v;
    } t_wr_req;

endpackage

`default_nettype wire

@@ design/amgs_ram.sv @@
// amgs_ram: generic simple dual port ram, one write and one registered read port
// no dependencies; read returns the contents before a same-edge write
`default_nettype none

module amgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/amgs_matrix.sv @@
// amgs_matrix: edge bit matrix stored as one 1-bit ram per column
// depends on amgs_pkg and amgs_ram; clears itself after reset, forwards the last write
`default_nettype none

module amgs_matrix (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire amgs_pkg::t_addr  i_rd_row,
    input  wire amgs_pkg::t_wr_req i_wr,
    output amgs_pkg::t_row        o_row,
    output logic                  o_clearing
);

    logic              r_clearing;
    amgs_pkg::t_addr   r_clr_addr;
    amgs_pkg::t_addr   r_rd_row;
    amgs_pkg::t_wr_req r_byp;
    amgs_pkg::t_row    ram_q;

    // clearing pass over all rows after reset, and capture of the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_byp      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + amgs_pkg::t_addr'(1);
                if (r_clr_addr == amgs_pkg::t_addr'(amgs_pkg::VERTICES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_wr.en) begin
                r_byp <= i_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= i_rd_row;
        end
    end

    // one ram per column: bit (u,v) lives in column v at address u
    for (genvar c = 0; c < amgs_pkg::VERTICES; c++) begin : g_col
        logic            we;
        amgs_pkg::t_addr waddr;
        logic            wdata;
        logic            hit_v;
        logic            hit_u;

        assign hit_v = i_wr.en && (i_wr.v == amgs_pkg::t_addr'(c));
        assign hit_u = i_wr.en && i_wr.mirror && (i_wr.u == amgs_pkg::t_addr'(c));

        always_comb begin
            if (r_clearing) begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = 1'b0;
            end else begin
                we    = hit_v || hit_u;
                waddr = hit_v ? i_wr.u : i_wr.v;
                wdata = i_wr.val;
            end
        end

        amgs_ram #(
            .WIDTH (1),
            .DEPTH (amgs_pkg::VERTICES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (i_rd_en),
            .i_raddr (i_rd_row),
            .o_rdata (ram_q[c])
        );
    end

    // patch in the write that landed on the same edge as the read
    always_comb begin
        o_row = ram_q;
        if (r_byp.en) begin
            if (r_byp.u == r_rd_row) begin
                o_row[r_byp.v] = r_byp.val;
            end
            if (r_byp.mirror && (r_byp.v == r_rd_row)) begin
                o_row[r_byp.u] = r_byp.val;
            end
        end
    end

    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

@@ design/adjacency_matrix_graph_store.sv @@
// pipeline: row read and item register on the input transfer, then the result register
// throughput: one item per cycle unless the output stalls or clearing runs; the column rams
// take one read and one write per edge; an item's write is forwarded into the next row read
// reset: synchronous, active low; afterwards a clearing pass over all VERTICES rows (64)
// zeroes the matrix while o_in_ready stays low; config writes are taken throughout
// adjacency_matrix_graph_store: top level, depends on amgs_pkg and amgs_matrix
`default_nettype none

module adjacency_matrix_graph_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [amgs_pkg::OP_W-1:0]     i_operation,
    input  wire logic [amgs_pkg::VERTEX_W-1:0] i_row_vertex,
    input  wire logic [amgs_pkg::VERTEX_W-1:0] i_column_vertex,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_edge_present,
    output logic                               o_found,
    output logic [amgs_pkg::VERTEX_W-1:0]      o_neighbor,
    output logic                               o_at_end,
    output logic [amgs_pkg::COUNT_W-1:0]       o_edge_count
);

    logic                      r_directed;
    logic                      r_s1_valid;
    logic [amgs_pkg::OP_W-1:0] r_s1_op;
    amgs_pkg::t_vtx            r_s1_u;
    amgs_pkg::t_vtx            r_s1_v;
    amgs_pkg::t_vtx            r_cursor_vertex;
    amgs_pkg::t_next           r_cursor_next;
    amgs_pkg::t_count          r_count;
    logic                      r_out_valid;

    amgs_pkg::t_vtx            n_cursor_vertex;
    amgs_pkg::t_next           n_cursor_next;
    amgs_pkg::t_count          n_count;

    logic                      in_xfer;
    logic                      s1_fire;
    logic                      clearing;
    amgs_pkg::t_vtx            rd_vtx;
    amgs_pkg::t_row            row;
    amgs_pkg::t_wr_req         wr;

    logic                      inrange;
    logic                      bit_uv;
    logic                      is_walk;
    amgs_pkg::t_vtx            wk_vtx;
    amgs_pkg::t_next           wk_start;
    logic                      wk_ok;
    logic                      hit;
    amgs_pkg::t_addr           hit_idx;
    logic                      res_present;
    logic                      res_found;
    logic                      res_end;

    // handshake
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clearing && (!r_s1_valid || s1_fire);
    assign in_xfer    = i_in_valid && o_in_ready;

    // row to read: next walks the cursor row as left by the item ahead
    always_comb begin
        if (i_operation == amgs_pkg::OP_NEXT) begin
            if (r_s1_valid && (r_s1_op == amgs_pkg::OP_BEGIN)) begin
                rd_vtx = r_s1_u;
            end else begin
                rd_vtx = r_cursor_vertex;
            end
        end else begin
            rd_vtx = i_row_vertex;
        end
    end

    amgs_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_rd_row   (amgs_pkg::t_addr'(rd_vtx)),
        .i_wr       (wr),
        .o_row      (row),
        .o_clearing (clearing)
    );

    // edge lookup on the row just read
    assign inrange = ({1'b0, r_s1_u} < amgs_pkg::VLIMIT) && ({1'b0, r_s1_v} < amgs_pkg::VLIMIT);
    assign bit_uv  = inrange && row[amgs_pkg::t_addr'(r_s1_v)];

    // write request for insert and remove
    always_comb begin
        wr.en     = s1_fire && inrange
                    && ((r_s1_op == amgs_pkg::OP_INSERT) || (r_s1_op == amgs_pkg::OP_REMOVE));
        wr.mirror = !r_directed;
        wr.val    = (r_s1_op == amgs_pkg::OP_INSERT);
        wr.u      = amgs_pkg::t_addr'(r_s1_u);
        wr.v      = amgs_pkg::t_addr'(r_s1_v);
    end

    // walk: priority encoder for the lowest set column at or after the start
    assign is_walk  = (r_s1_op == amgs_pkg::OP_BEGIN) || (r_s1_op == amgs_pkg::OP_NEXT);
    assign wk_vtx   = (r_s1_op == amgs_pkg::OP_BEGIN) ? r_s1_u : r_cursor_vertex;
    assign wk_start = (r_s1_op == amgs_pkg::OP_BEGIN) ? '0 : r_cursor_next;
    assign wk_ok    = ({1'b0, wk_vtx} < amgs_pkg::VLIMIT) && (wk_start < amgs_pkg::NEXT_END);

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int c = amgs_pkg::VERTICES - 1; c >= 0; c--) begin
            if (row[c] && (amgs_pkg::t_next'(c) >= wk_start)) begin
                hit     = 1'b1;
                hit_idx = amgs_pkg::t_addr'(c);
            end
        end
    end

    // per-operation results, count and cursor update
    always_comb begin
        n_count         = r_count;
        n_cursor_vertex = r_cursor_vertex;
        n_cursor_next   = r_cursor_next;
        res_present     = 1'b0;
        res_found       = 1'b0;
        res_end         = 1'b0;
        case (r_s1_op)
            amgs_pkg::OP_INSERT: begin
                if (inrange && !bit_uv && (r_count != amgs_pkg::COUNT_MAX)) begin
                    n_count = r_count + amgs_pkg::t_count'(1);
                end
            end
            amgs_pkg::OP_REMOVE: begin
                if (bit_uv && (r_count != '0)) begin
                    n_count = r_count - amgs_pkg::t_count'(1);
                end
            end
            amgs_pkg::OP_QUERY: begin
                res_present = bit_uv;
            end
            default: begin
            end
        endcase
        if (is_walk) begin
            n_cursor_vertex = wk_vtx;
            if (wk_ok && hit) begin
                res_found     = 1'b1;
                n_cursor_next = amgs_pkg::t_next'(hit_idx) + amgs_pkg::t_next'(1);
            end else begin
                res_end       = 1'b1;
                n_cursor_next = amgs_pkg::NEXT_END;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed      <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_count         <= '0;
            r_cursor_vertex <= '0;
            r_cursor_next   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_directed <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid     <= 1'b1;
                r_count         <= n_count;
                r_cursor_vertex <= n_cursor_vertex;
                r_cursor_next   <= n_cursor_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item register and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_op <= i_operation;
            r_s1_u  <= i_row_vertex;
            r_s1_v  <= i_column_vertex;
        end
        if (s1_fire) begin
            o_edge_present <= res_present;
            o_found        <= res_found;
            o_neighbor     <= res_found ? amgs_pkg::t_vtx'(hit_idx) : '0;
            o_at_end       <= res_end;
            o_edge_count   <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((amgs_pkg::t_count'(r_count - $past(r_count)) == amgs_pkg::t_count'(1))
             || (amgs_pkg::t_count'($past(r_count) - r_count) == amgs_pkg::t_count'(1))))
        else $error("edge count jumped by more than one");

    // count only changes when an item leaves the lookup stage
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_count))
        else $error("edge count changed without a finished item");

    // a new result only follows a finished item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_fire))
        else $error("result valid without a finished item");

endmodule

`default_nettype wire
